### design/ptf_pkg.sv
// Shared constants and types of the polygon fan triangulator.
`default_nettype none
package ptf_pkg;

  localparam int MAX_FACE_DEF = 64;   // corners held per face
  localparam int FILL_W       = 7;    // holds a corner count up to 64
  localparam int VID_W        = 32;   // signed corner index on the input
  localparam int IDX_W        = 31;   // stored corner index, also the vertex limit
  localparam int CFG_IDX_W    = 1;
  localparam int QUEUE_DEPTH  = 2;    // one job per face bank

  localparam logic [CFG_IDX_W-1:0] CFG_WINDING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT  = 1'd1;

  localparam logic STATUS_TRI    = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Work handed from the front to the back for one finished face.
  typedef struct packed {
    logic              reject;
    logic              bank;
    logic [FILL_W-1:0] fill;
  } job_t;

  // Face store write, driven by the front.
  typedef struct packed {
    logic              en;
    logic [FILL_W-1:0] addr;
    logic [IDX_W-1:0]  data;
  } wr_t;

  // Back tells the front that a bank has been fully read.
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage
`default_nettype wire

### design/ptf_ifs.sv
// Valid/ready channel interfaces for corner items and triangle items.
`default_nettype none
interface ptf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_of_mesh;
  logic signed [ptf_pkg::VID_W-1:0] vertex_id;
  logic                          end_of_face;

  modport source (output valid, output start_of_mesh, output vertex_id,
                  output end_of_face, input ready);
  modport sink   (input valid, input start_of_mesh, input vertex_id,
                  input end_of_face, output ready);
endinterface

interface ptf_out_if;
  logic                       valid;
  logic                       ready;
  logic [ptf_pkg::IDX_W-1:0]  corner_a;
  logic [ptf_pkg::IDX_W-1:0]  corner_b;
  logic [ptf_pkg::IDX_W-1:0]  corner_c;
  logic                       status;
  logic                       last_of_face;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output status, output last_of_face, input ready);
  modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                  input status, input last_of_face, output ready);
endinterface
`default_nettype wire

### design/polygon_fan_triangulator.sv
// Top level of the polygon fan triangulator: configuration registers and front/queue/back.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        start_of_mesh, vertex_id[31:0] signed, end_of_face
//  out_chan  out  valid/ready        corner_a/b/c[30:0], status, last_of_face
//  cfg_*     in   cfg_we, no ready   cfg_index[0], cfg_wdata[30:0]
//
// Corner items are taken one per cycle while in_chan.ready is high. The back sets up a face
// of n corners with a job take, an apex read, an apex load and a first neighbour load, then
// emits n-2 triangles at one per cycle unless out_chan stalls; a rejection goes out the cycle after its job is taken.
// Two face banks let the next face fill while the back walks the previous one; the
// front stalls only when both banks or both queue slots are in use.
// Reset is synchronous and active low; no clearing pass is needed.
// out_chan stalls hold the output register and pause the store reads.
`default_nettype none
module polygon_fan_triangulator #(
  parameter int MAX_FACE = ptf_pkg::MAX_FACE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ptf_in_if.sink                             in_chan,
  ptf_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptf_pkg::IDX_W-1:0]     cfg_wdata
);

  logic                      winding_r;
  logic [ptf_pkg::IDX_W-1:0] vcount_r;

  ptf_pkg::wr_t  st_wr;
  ptf_pkg::job_t job, head;
  ptf_pkg::rel_t rel;
  logic          job_push, q_pop, q_empty, q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      winding_r <= 1'b1;
      vcount_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptf_pkg::CFG_WINDING: winding_r <= cfg_wdata[0];
        ptf_pkg::CFG_VCOUNT:  vcount_r  <= cfg_wdata;
        default:              winding_r <= winding_r;
      endcase
    end
  end

  ptf_front #(.MAX_FACE(MAX_FACE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .vcount_lim (vcount_r),
    .st_wr      (st_wr),
    .job        (job),
    .job_push   (job_push),
    .q_full     (q_full),
    .rel        (rel)
  );

  ptf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job),
    .pop   (q_pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  ptf_back #(.MAX_FACE(MAX_FACE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .st_wr      (st_wr),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .winding_cw (winding_r),
    .rel        (rel),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire

### design/ptf_front.sv
// Front end: takes corner items, checks indices, fills a face bank, queues face jobs.
`default_nettype none
module ptf_front #(
  parameter int MAX_FACE = ptf_pkg::MAX_FACE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ptf_in_if.sink                         in_chan,
  input  wire logic [ptf_pkg::IDX_W-1:0] vcount_lim,
  output ptf_pkg::wr_t                   st_wr,
  output ptf_pkg::job_t                  job,
  output logic                           job_push,
  input  wire logic                      q_full,
  input  wire ptf_pkg::rel_t             rel
);

  localparam int AW = $clog2(MAX_FACE);
  localparam int FW = ptf_pkg::FILL_W;

  logic [FW-1:0] fill_r, fill_nxt;
  logic          bad_r, bad_nxt;
  logic          halted_r, halted_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          accept, live, eof, idx_ok, room;
  logic [FW-1:0] fill_e, fill_new;
  logic          bad_e, halt_e, bad_new;

  assign in_chan.ready = !q_full && !busy_r[bank_r];
  assign accept        = in_chan.valid && in_chan.ready;

  // start of mesh clears the face and the halt before this corner counts
  assign fill_e = in_chan.start_of_mesh ? '0 : fill_r;
  assign bad_e  = in_chan.start_of_mesh ? 1'b0 : bad_r;
  assign halt_e = in_chan.start_of_mesh ? 1'b0 : halted_r;

  assign idx_ok   = !in_chan.vertex_id[ptf_pkg::VID_W-1] &&
                    (in_chan.vertex_id[ptf_pkg::IDX_W-1:0] < vcount_lim);
  assign room     = fill_e < FW'(MAX_FACE);
  assign live     = accept && !halt_e;
  assign fill_new = room ? fill_e + FW'(1) : fill_e;
  assign bad_new  = bad_e || !idx_ok || !room;
  assign eof      = live && in_chan.end_of_face;

  always_comb begin
    st_wr.en   = live && room;
    st_wr.addr = FW'({bank_r, fill_e[AW-1:0]});
    st_wr.data = in_chan.vertex_id[ptf_pkg::IDX_W-1:0];
    job.reject = bad_new;
    job.bank   = bank_r;
    job.fill   = fill_new;
    job_push   = eof && (bad_new || fill_new >= FW'(3));
  end

  always_comb begin
    fill_nxt   = fill_r;
    bad_nxt    = bad_r;
    halted_nxt = halted_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      halted_nxt = halt_e;
      fill_nxt   = fill_e;
      bad_nxt    = bad_e;
      if (live) begin
        fill_nxt = eof ? '0 : fill_new;
        bad_nxt  = eof ? 1'b0 : bad_new;
        if (eof && bad_new) begin
          halted_nxt = 1'b1;
        end
        if (job_push && !bad_new) begin
          busy_nxt[bank_r] = 1'b1;
          bank_nxt         = !bank_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      bad_r    <= 1'b0;
      halted_r <= 1'b0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      fill_r   <= fill_nxt;
      bad_r    <= bad_nxt;
      halted_r <= halted_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

### design/ptf_queue.sv
// Two-entry job queue between front and back.
`default_nettype none
module ptf_queue (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire ptf_pkg::job_t din,
  input  wire logic    pop,
  output ptf_pkg::job_t head,
  output logic         empty,
  output logic         full
);

  localparam int PW = $clog2(ptf_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(ptf_pkg::QUEUE_DEPTH + 1);

  ptf_pkg::job_t q_r [ptf_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign head  = q_r[rp_r];
  assign empty = cnt_r == '0;
  assign full  = cnt_r == CW'(ptf_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/ptf_back.sv
// Back end: face store and fan sequencer that walks a bank and emits triangles.
`default_nettype none
module ptf_back #(
  parameter int MAX_FACE = ptf_pkg::MAX_FACE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ptf_pkg::wr_t  st_wr,
  input  wire ptf_pkg::job_t head,
  input  wire logic   q_empty,
  output logic        q_pop,
  input  wire logic   winding_cw,
  output ptf_pkg::rel_t rel,
  ptf_out_if.source   out_chan
);

  localparam int AW = $clog2(MAX_FACE);
  localparam int FW = ptf_pkg::FILL_W;
  localparam int IW = ptf_pkg::IDX_W;

  typedef enum logic [0:0] {S_IDLE, S_RUN} state_t;

  logic [IW-1:0] mem [2**(AW+1)];
  logic [IW-1:0] mem_q_r;

  state_t        state_r;
  ptf_pkg::job_t job_r;
  logic [FW-1:0] rd_idx_r, q_idx_r;
  logic          q_vld_r;
  logic [IW-1:0] apex_r, prev_r;
  logic          out_valid_r;
  logic [IW-1:0] out_a_r, out_b_r, out_c_r;
  logic          out_status_r, out_last_r;

  logic out_free, head_take, consume, issue, q_last, out_load;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign head_take = (state_r == S_IDLE) && !q_empty && (!head.reject || out_free);
  // apex and first neighbour load registers only; later corners need the output slot
  assign consume   = (state_r == S_RUN) && q_vld_r && (q_idx_r < FW'(2) || out_free);
  assign q_last    = (q_idx_r + FW'(1)) == job_r.fill;
  assign issue     = (state_r == S_RUN) && (rd_idx_r < job_r.fill) && (!q_vld_r || consume);
  assign q_pop     = head_take;
  assign out_load  = (head_take && head.reject) || (consume && q_idx_r >= FW'(2));

  always_comb begin
    rel.en   = consume && q_last;
    rel.bank = job_r.bank;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.corner_a     = out_a_r;
  assign out_chan.corner_b     = out_b_r;
  assign out_chan.corner_c     = out_c_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.last_of_face = out_last_r;

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      mem[st_wr.addr[AW:0]] <= st_wr.data;
    end
    if (issue) begin
      mem_q_r <= mem[{job_r.bank, rd_idx_r[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_chan.ready);
      unique case (state_r)
        S_IDLE: begin
          if (head_take) begin
            if (head.reject) begin
              out_a_r      <= '0;
              out_b_r      <= '0;
              out_c_r      <= '0;
              out_status_r <= ptf_pkg::STATUS_REJECT;
              out_last_r   <= 1'b1;
            end else begin
              job_r    <= head;
              rd_idx_r <= '0;
              state_r  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          q_vld_r <= issue || (q_vld_r && !consume);
          if (issue) begin
            rd_idx_r <= rd_idx_r + FW'(1);
            q_idx_r  <= rd_idx_r;
          end
          if (consume) begin
            if (q_idx_r == '0) begin
              apex_r <= mem_q_r;
            end else begin
              prev_r <= mem_q_r;
            end
            if (q_idx_r >= FW'(2)) begin
              out_a_r      <= apex_r;
              out_b_r      <= winding_cw ? prev_r : mem_q_r;
              out_c_r      <= winding_cw ? mem_q_r : prev_r;
              out_status_r <= ptf_pkg::STATUS_TRI;
              out_last_r   <= q_last;
            end
            if (q_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/ptf_checker.sv
// Port-level checks on the triangulator's result channel, bound to the top level.
`default_nettype none
module ptf_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [ptf_pkg::IDX_W-1:0] corner_a,
  input wire logic [ptf_pkg::IDX_W-1:0] corner_b,
  input wire logic [ptf_pkg::IDX_W-1:0] corner_c,
  input wire logic                      status,
  input wire logic                      last_of_face
);

  // a rejection carries no corners and closes its face
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ptf_pkg::STATUS_REJECT |->
      corner_a == '0 && corner_b == '0 && corner_c == '0 && last_of_face)
    else $error("rejection item malformed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(corner_a) && $stable(corner_b) &&
      $stable(corner_c) && $stable(status) && $stable(last_of_face))
    else $error("result changed while stalled");

endmodule

bind polygon_fan_triangulator ptf_checker u_ptf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .corner_a     (out_chan.corner_a),
  .corner_b     (out_chan.corner_b),
  .corner_c     (out_chan.corner_c),
  .status       (out_chan.status),
  .last_of_face (out_chan.last_of_face)
);
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the polygon fan triangulator.
`timescale 1ns / 100ps
module testbench;

  localparam int IDX_W = ptf_pkg::IDX_W;
  localparam int VID_W = ptf_pkg::VID_W;
  localparam int CFG_IDX_W = ptf_pkg::CFG_IDX_W;
  localparam int MAX_CORNERS = ptf_pkg::MAX_FACE_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 3000000;
  localparam logic [IDX_W-1:0] TOP_INDEX = '1;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             status;
    logic             last;
  } tri_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IDX_W-1:0]     cfg_wdata;

  ptf_in_if  in_chan ();
  ptf_out_if out_chan ();

  polygon_fan_triangulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: configuration and face state
  logic             keep_order = 1'b1;
  logic [IDX_W-1:0] vertex_limit = '0;
  logic [IDX_W-1:0] face_copy [MAX_CORNERS];
  int unsigned      corners_held = 0;
  bit               face_rejected = 1'b0;
  bit               mesh_stopped = 1'b0;

  tri_t        pending_tris [$];
  int unsigned mismatches = 0;
  int unsigned corners_taken = 0;
  int unsigned next_gap = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  bit          in_busy = 1'b0;
  bit          no_stalls = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Works out the triangle items one accepted corner item causes.
  // Returns 0 when the item is dropped by a halted mesh.
  function automatic bit fan_predict(input logic som, input logic [VID_W-1:0] vid,
                                     input logic eof);
    tri_t t;
    if (som) begin
      mesh_stopped = 1'b0;
      corners_held = 0;
      face_rejected = 1'b0;
    end
    if (mesh_stopped) return 1'b0;
    if (vid[VID_W-1] || vid[IDX_W-1:0] >= vertex_limit) face_rejected = 1'b1;
    if (corners_held < MAX_CORNERS) begin
      face_copy[corners_held] = vid[IDX_W-1:0];
      corners_held++;
    end else begin
      face_rejected = 1'b1;
    end
    if (eof) begin
      if (face_rejected) begin
        t = '{a: '0, b: '0, c: '0, status: ptf_pkg::STATUS_REJECT, last: 1'b1};
        pending_tris = {pending_tris, t};
        mesh_stopped = 1'b1;
      end else begin
        for (int i = 2; i < corners_held; i++) begin
          t.a = face_copy[0];
          t.b = keep_order ? face_copy[i-1] : face_copy[i];
          t.c = keep_order ? face_copy[i] : face_copy[i-1];
          t.status = ptf_pkg::STATUS_TRI;
          t.last = (i + 1 == corners_held);
          pending_tris = {pending_tris, t};
        end
      end
      corners_held = 0;
      face_rejected = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_stalls) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [VID_W-1:0] good_corner();
    logic [IDX_W-1:0] v;
    if (vertex_limit == 0) return $urandom;   // nothing can be valid
    v = IDX_W'($urandom_range(vertex_limit - 1, 0));
    return {1'b0, v};
  endfunction

  function automatic logic [VID_W-1:0] bad_corner();
    logic [IDX_W-1:0] v;
    if ($urandom_range(1) == 0) begin
      v = IDX_W'($urandom);
      return {1'b1, v};
    end
    v = IDX_W'($urandom_range(TOP_INDEX, vertex_limit));
    return {1'b0, v};
  endfunction

  // valid stays high into the next item when no gap follows
  task automatic send_corner(input logic som, input logic [VID_W-1:0] vid, input logic eof);
    repeat (next_gap) @(posedge clk);
    in_chan.valid         <= 1'b1;
    in_chan.start_of_mesh <= som;
    in_chan.vertex_id     <= vid;
    in_chan.end_of_face   <= eof;
    in_busy = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    if (fan_predict(som, vid, eof)) corners_taken++;
    next_gap = pick_gap();
    if (next_gap > 0) begin
      in_chan.valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  // Must run in the same step as the last acceptance.
  task automatic pause_until_drained();
    if (in_busy) begin
      in_chan.valid <= 1'b0;
      in_busy = 1'b0;
    end
    next_gap = 0;
    do @(posedge clk); while (pending_tris.size() != 0);
  endtask

  task automatic wait_drain();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic win, input logic [IDX_W-1:0] vc);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= ptf_pkg::CFG_WINDING;
    cfg_wdata <= {{(IDX_W-1){1'b0}}, win};
    @(posedge clk);
    cfg_index <= ptf_pkg::CFG_VCOUNT;
    cfg_wdata <= vc;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_order = win;
    vertex_limit = vc;
  endtask

  // One face with random valid corners; bad_at >= len means no bad corner.
  task automatic send_face(input bit som, input int unsigned len, input int unsigned bad_at,
                           input bit finish);
    for (int unsigned k = 0; k < len; k++)
      send_corner(k == 0 ? som : 1'b0, k == bad_at ? bad_corner() : good_corner(),
                  finish && k == len - 1);
  endtask

  // Reset values: vertex count 0 makes every index bad
  task automatic test_reset_state();
    send_corner(1'b1, 32'd0, 1'b0);
    send_corner(1'b0, 32'd1, 1'b0);
    send_corner(1'b0, 32'd2, 1'b1);
    send_corner(1'b0, 32'd5, 1'b1);   // dropped, mesh halted
    send_corner(1'b1, 32'd7, 1'b1);
  endtask

  task automatic test_winding();
    write_config(1'b1, TOP_INDEX);
    send_corner(1'b1, 32'h7FFF_FFFE, 1'b0);
    send_corner(1'b0, 32'd0, 1'b0);
    send_corner(1'b0, 32'h5555_5555, 1'b0);
    send_corner(1'b0, 32'h2AAA_AAAA, 1'b1);
    write_config(1'b0, TOP_INDEX);
    send_corner(1'b1, 32'h7FFF_FFFE, 1'b0);
    send_corner(1'b0, 32'd0, 1'b0);
    send_corner(1'b0, 32'h5555_5555, 1'b0);
    send_corner(1'b0, 32'h2AAA_AAAA, 1'b1);
  endtask

  task automatic test_index_limits();
    send_corner(1'b1, {1'b0, TOP_INDEX}, 1'b1);   // equal to the count
    send_corner(1'b1, 32'hFFFF_FFFF, 1'b0);
    send_corner(1'b0, 32'd1, 1'b1);
    send_corner(1'b1, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_short_faces();
    write_config(1'b1, 31'd16);
    send_corner(1'b1, 32'd3, 1'b1);
    send_corner(1'b0, 32'd4, 1'b0);
    send_corner(1'b0, 32'd5, 1'b1);
    send_corner(1'b0, 32'd6, 1'b0);
    send_corner(1'b0, 32'd7, 1'b0);   // left open, dropped by the next start
    send_corner(1'b1, 32'd8, 1'b0);
    send_corner(1'b0, 32'd9, 1'b0);
    send_corner(1'b0, 32'd15, 1'b1);
  endtask

  // Longest fan, then one corner too many, then recovery
  task automatic test_full_faces();
    write_config(1'b1, TOP_INDEX);
    send_face(1'b1, MAX_CORNERS, MAX_CORNERS, 1'b1);
    send_face(1'b0, MAX_CORNERS + 1, MAX_CORNERS + 1, 1'b1);
    send_face(1'b1, 3, 3, 1'b1);
  endtask

  task automatic random_faces(input int unsigned corner_goal);
    int unsigned stop_at;
    int unsigned len;
    int unsigned r;
    bit som;
    bit broken;
    bit need_start;
    stop_at = corners_taken + corner_goal;
    need_start = 1'b1;
    while (corners_taken < stop_at) begin
      if ($urandom_range(19) == 0) begin
        send_corner(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));   // noise
      end else begin
        if (need_start || mesh_stopped) som = ($urandom_range(9) != 0);
        else som = ($urandom_range(9) == 0);
        r = $urandom_range(99);
        if (r < 10) len = $urandom_range(2, 1);
        else if (r < 95) len = $urandom_range(10, 3);
        else len = $urandom_range(24, 11);
        broken = ($urandom_range(24) == 0);
        send_face(som, len, ($urandom_range(7) == 0) ? $urandom_range(len - 1, 0) : len,
                  !broken);
        need_start = broken;
      end
      if ($urandom_range(29) == 0) pause_until_drained();
    end
  endtask

  task automatic test_random_stream();
    write_config(1'b1, TOP_INDEX);
    random_faces(12);
    write_config(1'b0, IDX_W'($urandom_range(300, 3)));
    random_faces(10);
    write_config(1'b1, 31'd1);
    random_faces(6);
    write_config(1'b0, TOP_INDEX);
    no_stalls = 1'b1;
    random_faces(10);
    pause_until_drained();
    no_stalls = 1'b0;
    write_config(1'b1, IDX_W'($urandom));
    random_faces(10);
    write_config(1'b0, 31'd0);
    random_faces(4);
  endtask

  // Random receiver stalls, mostly short
  always @(posedge clk) begin
    if (ready_hold > 0) ready_hold = ready_hold - 1;
    else if (!no_stalls && $urandom_range(99) < 20)
      ready_hold = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    out_chan.ready <= (ready_hold == 0);
  end

  always @(posedge clk) begin
    tri_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_tris.size() == 0) begin
        flag_mismatch("triangle item with nothing pending");
      end else begin
        want = pending_tris.pop_front();
        if (out_chan.corner_a !== want.a)
          flag_mismatch($sformatf("corner_a got %0d want %0d", out_chan.corner_a, want.a));
        if (out_chan.corner_b !== want.b)
          flag_mismatch($sformatf("corner_b got %0d want %0d", out_chan.corner_b, want.b));
        if (out_chan.corner_c !== want.c)
          flag_mismatch($sformatf("corner_c got %0d want %0d", out_chan.corner_c, want.c));
        if (out_chan.status !== want.status)
          flag_mismatch($sformatf("status got %b want %b", out_chan.status, want.status));
        if (out_chan.last_of_face !== want.last)
          flag_mismatch($sformatf("last_of_face got %b want %b", out_chan.last_of_face,
                                  want.last));
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL polygon_fan_triangulator");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.start_of_mesh = 1'b0;
    in_chan.vertex_id = '0;
    in_chan.end_of_face = 1'b0;
    out_chan.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ptf_pkg::CFG_WINDING;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_winding();
    test_index_limits();
    test_short_faces();
    test_full_faces();
    test_random_stream();
    wait_drain();
    if (mismatches == 0)
      $display("PASS polygon_fan_triangulator");
    else
      $display("FAIL polygon_fan_triangulator");
    $finish;
  end
endmodule
